FILE: hw/rtl/qte_pkg.sv
package qte_pkg;

    // Data path widths.
    localparam int QW  = 16;   // quaternion component, Q2.14
    localparam int CW  = 36;   // CORDIC x/y working width
    localparam int AW  = 28;   // angle accumulator, scale 2^24 radians
    localparam int TW  = 30;   // clamped pole test value, signed
    localparam int RW  = 29;   // square root result width
    localparam int VW  = 57;   // square root working width
    localparam int SQRT_LAT = 31;

    // Pole codes carried on m_tuser.
    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_t;

    // Angle constants.
    localparam logic signed [AW-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam int OUT_PI      = 25736;
    localparam int OUT_TWO_PI  = 51472;
    localparam int OUT_HALF_PI = 12868;
    localparam int MAX_STAGES  = 24;

    // Arctangent of 2^-i at scale 2^24.
    localparam logic signed [AW-1:0] ATAN_TAB [0:MAX_STAGES-1] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
        28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
        28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
        28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
    };

endpackage

FILE: hw/rtl/qte_cordic.sv
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [qte_pkg::CW-1:0]  y_in,
    input  logic signed [qte_pkg::CW-1:0]  x_in,
    output logic signed [qte_pkg::AW-1:0]  ang_out
);
    import qte_pkg::*;

    logic signed [CW-1:0] x_reg   [0:STAGES];
    logic signed [CW-1:0] y_reg   [0:STAGES];
    logic signed [AW-1:0] ang_reg [0:STAGES];
    logic                 zero_reg [0:STAGES];

    // Quadrant pre-rotation so the vector starts in the right half plane.
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_reg[0]   <= y_in;
                    y_reg[0]   <= -x_in;
                    ang_reg[0] <= ANG_HALF_PI;
                end else begin
                    x_reg[0]   <= -y_in;
                    y_reg[0]   <= x_in;
                    ang_reg[0] <= -ANG_HALF_PI;
                end
            end else begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                ang_reg[0] <= '0;
            end
        end
    end

    // One micro-rotation per register stage, driving y toward zero.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] < 0) begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] - ATAN_TAB[i];
                end else begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] + ATAN_TAB[i];
                end
            end
        end
    end

    // A zero vector has angle zero.
    assign ang_out = zero_reg[STAGES] ? '0 : ang_reg[STAGES];

endmodule

FILE: hw/rtl/qte_isqrt.sv
module qte_isqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [qte_pkg::TW-1:0] t_in,
    output logic [qte_pkg::RW-1:0]        root_out
);
    import qte_pkg::*;

    localparam int STEPS = RW;

    logic [RW-1:0] t_abs;
    logic [13:0]   t_hi;
    logic [14:0]   t_lo;
    logic [27:0]   hh_reg;
    logic [28:0]   hl_reg;
    logic [29:0]   ll_reg;
    logic [57:0]   sq;
    logic [57:0]   rem;
    logic [VW-1:0] v_reg [0:STEPS];
    logic [VW-1:0] r_reg [0:STEPS];

    // Split |t| so each partial product stays narrow.
    assign t_abs = t_in[TW-1] ? RW'(-t_in) : RW'(t_in);
    assign t_hi  = t_abs[28:15];
    assign t_lo  = t_abs[14:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg <= t_hi * t_hi;
            hl_reg <= t_hi * t_lo;
            ll_reg <= t_lo * t_lo;
        end
    end

    // Radicand 1 - t^2 at scale 2^56.
    assign sq  = (58'(hh_reg) << 30) + (58'(hl_reg) << 16) + 58'(ll_reg);
    assign rem = (58'(1) << 56) - sq;

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0] <= rem[VW-1:0];
            r_reg[0] <= '0;
        end
    end

    // Restoring square root, one result bit per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (STEPS - 1 - k));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (v_reg[k] >= r_reg[k] + BIT) begin
                    v_reg[k+1] <= v_reg[k] - (r_reg[k] + BIT);
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
                end else begin
                    v_reg[k+1] <= v_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
            end
        end
    end

    assign root_out = r_reg[STEPS][RW-1:0];

endmodule

FILE: hw/rtl/quaternion_to_euler.sv
// Converts one unit quaternion per transaction (s_tdata: quat_x, quat_y,
// quat_z, quat_w, signed Q2.14, lowest bits first) into roll (signed Q4.13),
// yaw (signed Q3.13) and pitch (signed Q2.13) radians, with the pole case on
// m_tuser. The pipeline takes a new transaction every clock while the output
// is free. Each one passes through the product stage, the sum stage, the
// squaring and bit-per-stage square root registers that feed the pitch
// arctangent, then CORDIC_STAGES + 1 CORDIC stages and the output register.
// A held m_tready stalls the whole pipeline without losing data.
// cfg_wdata is written to the pole threshold (unsigned Q1.14, reset 16383)
// on every clock with cfg_wen high; write it only while the block is idle.
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, yaw_angle, pitch_angle
    output logic [1:0]  m_tuser    // pole_case
);
    import qte_pkg::*;

    localparam int LAT = CORDIC_STAGES + SQRT_LAT + 4;
    localparam int PCD = CORDIC_STAGES + SQRT_LAT + 1;

    logic        en;
    logic [14:0] limit_reg;
    logic        vld_reg [0:LAT-1];

    logic signed [QW-1:0] qx, qy, qz, qw;
    logic signed [31:0] yw_reg, xz_reg, xy_reg, zw_reg, yz_reg, xw_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg, sw_reg;
    logic signed [QW-1:0] x1_reg, w1_reg;

    logic signed [33:0] test;
    logic signed [33:0] lim;
    logic signed [33:0] roll_num, roll_den, yaw_num, yaw_den;
    logic               north, south;
    logic signed [CW-1:0] roll_y_reg, roll_x_reg, yaw_y_reg, yaw_x_reg;
    logic signed [TW-1:0] t_reg;
    pole_t                pc_reg;

    logic signed [AW-1:0] roll_ang, yaw_ang, pitch_ang;
    logic [RW-1:0]        root;
    logic signed [AW-1:0] roll_dly_reg [0:SQRT_LAT-1];
    logic signed [AW-1:0] yaw_dly_reg  [0:SQRT_LAT-1];
    logic signed [TW-1:0] t_dly_reg    [0:SQRT_LAT-1];
    pole_t                pc_dly_reg   [0:PCD-1];

    logic signed [29:0] roll_pole;
    logic signed [18:0] roll_q, yaw_q, pitch_q;
    logic [16:0]        roll_out;
    logic [15:0]        yaw_out;
    logic [14:0]        pitch_out;
    pole_t              pc_out;

    // Rounds a 2^24 angle to Q6.13.
    function automatic logic signed [18:0] to_q13(input logic signed [29:0] a);
        logic signed [29:0] s;
        s = (a + 30'sd1024) >>> 11;
        return s[18:0];
    endfunction

    function automatic logic signed [18:0] sat(input logic signed [18:0] v, input int lim_v);
        logic signed [18:0] l;
        l = 19'(lim_v);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    // The whole pipeline moves whenever the output register can take data.
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    // Pole threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 15'd16383;
        end else if (cfg_wen) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // X and Y trade roles relative to the input order.
    assign qy = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];

    // Stage 1: all pairwise products.
    always_ff @(posedge aclk) begin
        if (en) begin
            yw_reg <= qy * qw;
            xz_reg <= qx * qz;
            xy_reg <= qx * qy;
            zw_reg <= qz * qw;
            yz_reg <= qy * qz;
            xw_reg <= qx * qw;
            sx_reg <= qx * qx;
            sy_reg <= qy * qy;
            sz_reg <= qz * qz;
            sw_reg <= qw * qw;
            x1_reg <= qx;
            w1_reg <= qw;
        end
    end

    // Stage 2: sums, pole decision and test clamp.
    assign test     = (34'(yw_reg) - 34'(xz_reg)) <<< 1;
    assign lim      = 34'({limit_reg, 14'd0});
    assign north    = test > lim;
    assign south    = test < -lim;
    assign roll_num = (34'(xy_reg) + 34'(zw_reg)) <<< 1;
    assign roll_den = 34'(sx_reg) - 34'(sy_reg) - 34'(sz_reg) + 34'(sw_reg);
    assign yaw_num  = (34'(yz_reg) + 34'(xw_reg)) <<< 1;
    assign yaw_den  = 34'(sz_reg) + 34'(sw_reg) - 34'(sx_reg) - 34'(sy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (north || south) begin
                roll_y_reg <= CW'(x1_reg) <<< 14;
                roll_x_reg <= CW'(w1_reg) <<< 14;
            end else begin
                roll_y_reg <= CW'(roll_num);
                roll_x_reg <= CW'(roll_den);
            end
            yaw_y_reg <= CW'(yaw_num);
            yaw_x_reg <= CW'(yaw_den);
            if (test > 34'sd268435456)       t_reg <= TW'(268435456);
            else if (test < -34'sd268435456) t_reg <= -TW'(268435456);
            else                             t_reg <= TW'(test);
            pc_reg <= north ? POLE_NORTH : (south ? POLE_SOUTH : POLE_NONE);
        end
    end

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk(aclk), .en(en), .y_in(roll_y_reg), .x_in(roll_x_reg), .ang_out(roll_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .aclk(aclk), .en(en), .y_in(yaw_y_reg), .x_in(yaw_x_reg), .ang_out(yaw_ang)
    );

    qte_isqrt u_sqrt (
        .aclk(aclk), .en(en), .t_in(t_reg), .root_out(root)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk(aclk), .en(en), .y_in(CW'(t_dly_reg[SQRT_LAT-1])), .x_in(CW'(root)),
        .ang_out(pitch_ang)
    );

    // Delay lines that line roll, yaw and the pole code up with pitch, and t up with the square root.
    always_ff @(posedge aclk) begin
        if (en) begin
            roll_dly_reg[0] <= roll_ang;
            yaw_dly_reg[0]  <= yaw_ang;
            t_dly_reg[0]    <= t_reg;
            pc_dly_reg[0]   <= pc_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
                t_dly_reg[i]    <= t_dly_reg[i-1];
            end
            for (int i = 1; i < PCD; i++) pc_dly_reg[i] <= pc_dly_reg[i-1];
        end
    end

    // Output formatting: rounding, pole substitution and range guard.
    always_comb begin
        pc_out    = pc_dly_reg[PCD-1];
        roll_pole = 30'(roll_dly_reg[SQRT_LAT-1]) <<< 1;
        if (pc_out == POLE_NORTH) roll_pole = -roll_pole;
        roll_q  = sat(to_q13(30'(roll_dly_reg[SQRT_LAT-1])), OUT_PI);
        yaw_q   = sat(to_q13(30'(yaw_dly_reg[SQRT_LAT-1])), OUT_PI);
        pitch_q = sat(to_q13(30'(pitch_ang)), OUT_HALF_PI);
        case (pc_out)
            POLE_NORTH, POLE_SOUTH: begin
                roll_out  = 17'(sat(to_q13(roll_pole), OUT_TWO_PI));
                yaw_out   = '0;
                pitch_out = (pc_out == POLE_NORTH) ? 15'(OUT_HALF_PI) : -15'(OUT_HALF_PI);
            end
            default: begin
                roll_out  = roll_q[16:0];
                yaw_out   = yaw_q[15:0];
                pitch_out = pitch_q[14:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {pitch_out, yaw_out, roll_out};
            m_tuser <= pc_out;
        end
    end

endmodule

FILE: hw/rtl/qte_checker.sv
module qte_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import qte_pkg::*;

    // A delivered pole code is always one of the three defined cases.
    a_pole_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == POLE_NONE || m_tuser == POLE_NORTH || m_tuser == POLE_SOUTH))
        else $error("undefined pole code");

    // At either pole yaw is reported as zero.
    a_pole_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != POLE_NONE) |-> (m_tdata[32:17] == 16'd0))
        else $error("nonzero yaw at a pole");

    // The north pole reports pitch of plus half pi.
    a_pole_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == POLE_NORTH) |-> (m_tdata[47:33] == 15'(OUT_HALF_PI)))
        else $error("wrong pitch at the north pole");

    // A stalled result stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind quaternion_to_euler qte_port_checker u_qte_port_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
